// File: hw/rtl/rlfc_pkg.sv
// Shared types, codes and helpers for the route lookup and flow cache block.
`timescale 1ns / 1ps
`default_nettype none
package rlfc_pkg;

   localparam int ROUTE_ENTRIES_DEF = 32;
   localparam int FLOW_ENTRIES_DEF  = 1024;
   localparam int ADDR_W            = 32;
   localparam int PLEN_W            = 6;
   localparam int STATUS_W          = 2;
   localparam int RIDX_W            = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED = 2'd0,
      ST_FULL  = 2'd1,
      ST_FOUND = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PLEN_W-1:0] plen;
   } route_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              found;
   } query_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] m;
      if (plen >= PLEN_W'(ADDR_W)) begin
         m = '1;
      end else begin
         m = ~({ADDR_W{1'b1}} >> plen);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rlfc_cell.sv
// One route cell: holds a route, shifts on add, checks a passing lookup.
`timescale 1ns / 1ps
`default_nettype none
module rlfc_cell #(
   parameter int ROUTE_ENTRIES = rlfc_pkg::ROUTE_ENTRIES_DEF,
   parameter int CELL_INDEX    = 0,
   localparam int IW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
   localparam int RCW = $clog2(ROUTE_ENTRIES + 1)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  shift_en,
   input  rlfc_pkg::route_type  route_in,
   input  wire [IW-1:0]         idx_in,
   output rlfc_pkg::route_type  route_out,
   output logic [IW-1:0]        idx_out,
   input  wire [RCW-1:0]        route_count,
   input  rlfc_pkg::query_type  query_in,
   input  wire [IW-1:0]         qidx_in,
   output rlfc_pkg::query_type  query_out,
   output logic [IW-1:0]        qidx_out
);

   rlfc_pkg::route_type route_ff;
   logic [IW-1:0]       idx_ff;
   rlfc_pkg::query_type query_ff, query_in_n;
   logic [IW-1:0]       qidx_ff, qidx_in_n;
   logic                active, match;

   assign active = RCW'(CELL_INDEX) < route_count;
   assign match  = route_ff.addr == (query_in.addr & rlfc_pkg::prefix_mask(route_ff.plen));

   always_comb begin
      query_in_n.valid = query_in.valid;
      query_in_n.addr  = query_in.addr;
      query_in_n.found = query_in.found | (active & match);
      qidx_in_n        = query_in.found ? qidx_in : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         route_ff <= route_in;
         idx_ff   <= idx_in;
      end
      query_ff.addr  <= query_in_n.addr;
      query_ff.found <= query_in_n.found;
      qidx_ff        <= qidx_in_n;
      if (reset) begin
         query_ff.valid <= 1'b0;
      end else begin
         query_ff.valid <= query_in_n.valid;
      end
   end

   assign route_out = route_ff;
   assign idx_out   = idx_ff;
   assign query_out = query_ff;
   assign qidx_out  = qidx_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ipv4_route_lookup_flow_cache.sv
// Top level: flow cache memory scan, route cell chain and response register.
`timescale 1ns / 1ps
`default_nettype none
// An add response is registered straight from the request. A lookup first
// scans the flow cache memory, one entry a cycle through its registered read
// port, and a hit is answered from that port. On a miss the address then
// walks the row of ROUTE_ENTRIES route cells, one cell a cycle. One request
// is in flight at a time, and a new one is taken once the previous response
// has been delivered. Route cells hold the newest route first. Flow slots
// are never freed.
module ipv4_route_lookup_flow_cache #(
   parameter int ROUTE_ENTRIES = rlfc_pkg::ROUTE_ENTRIES_DEF,
   parameter int FLOW_ENTRIES  = rlfc_pkg::FLOW_ENTRIES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [39:0] req_tdata,   // ip_address[31:0], prefix_len[37:32], zero
   input  wire [0:0]  req_tuser,   // req_type[0]
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // route_index[4:0], zero
   output logic [2:0] rsp_tuser    // status[1:0], cache_hit[2]
);

   localparam int IW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
   localparam int FW  = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int FCW = $clog2(FLOW_ENTRIES + 1);
   localparam int AW  = rlfc_pkg::ADDR_W;
   localparam int XW  = rlfc_pkg::RIDX_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_ROUTE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [RCW-1:0]      rcount_ff, rcount_in;
   logic [FCW-1:0]      fcount_ff, fcount_in;
   logic [FCW-1:0]      ptr_ff, ptr_in;
   logic                rdv_ff, rdv_in;
   logic [AW-1:0]       qaddr_ff, qaddr_in;
   logic                launch_ff, launch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rlfc_pkg::status_type status_ff, status_in;
   logic [XW-1:0]       ridx_ff, ridx_in;
   logic                hit_ff, hit_in;

   logic [AW-1:0]       flow_addr_mem [FLOW_ENTRIES];
   logic [XW-1:0]       flow_route_mem [FLOW_ENTRIES];
   logic [AW-1:0]       rd_addr_q;
   logic [XW-1:0]       rd_route_q;
   logic                rd_en, wr_en;
   logic [XW-1:0]       wr_route;

   rlfc_pkg::route_type chain_route [ROUTE_ENTRIES+1];
   logic [IW-1:0]       chain_idx   [ROUTE_ENTRIES+1];
   rlfc_pkg::query_type chain_q     [ROUTE_ENTRIES+1];
   logic [IW-1:0]       chain_qidx  [ROUTE_ENTRIES+1];
   logic                shift_en;
   logic                req_fire;
   logic [31:0]         found_wide;
   logic [31:0]         add_wide;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   assign chain_route[0].addr = req_tdata[31:0];
   assign chain_route[0].plen = req_tdata[37:32];
   assign chain_idx[0]        = rcount_ff[IW-1:0];
   assign chain_q[0].valid    = launch_ff;
   assign chain_q[0].addr     = qaddr_ff;
   assign chain_q[0].found    = 1'b0;
   assign chain_qidx[0]       = '0;

   assign shift_en = req_fire && (req_tuser[0] == rlfc_pkg::REQ_ADD)
                     && (rcount_ff < RCW'(ROUTE_ENTRIES));

   for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_cell
      rlfc_cell #(
         .ROUTE_ENTRIES(ROUTE_ENTRIES),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .route_in   (chain_route[k]),
         .idx_in     (chain_idx[k]),
         .route_out  (chain_route[k+1]),
         .idx_out    (chain_idx[k+1]),
         .route_count(rcount_ff),
         .query_in   (chain_q[k]),
         .qidx_in    (chain_qidx[k]),
         .query_out  (chain_q[k+1]),
         .qidx_out   (chain_qidx[k+1])
      );
   end

   assign found_wide = 32'(chain_qidx[ROUTE_ENTRIES]);
   assign add_wide   = 32'(rcount_ff);
   assign wr_route   = found_wide[XW-1:0];

   always_comb begin
      state_in     = state_ff;
      rcount_in    = rcount_ff;
      fcount_in    = fcount_ff;
      ptr_in       = ptr_ff;
      rdv_in       = 1'b0;
      qaddr_in     = qaddr_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      ridx_in      = ridx_ff;
      hit_in       = hit_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == rlfc_pkg::REQ_ADD) begin
                  rsp_valid_in = 1'b1;
                  hit_in       = 1'b0;
                  if (shift_en) begin
                     status_in = rlfc_pkg::ST_ADDED;
                     ridx_in   = add_wide[XW-1:0];
                     rcount_in = rcount_ff + RCW'(1);
                  end else begin
                     status_in = rlfc_pkg::ST_FULL;
                     ridx_in   = '0;
                  end
               end else begin
                  qaddr_in = req_tdata[31:0];
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rdv_ff && (rd_addr_q == qaddr_ff)) begin
               rsp_valid_in = 1'b1;
               status_in    = rlfc_pkg::ST_FOUND;
               ridx_in      = rd_route_q;
               hit_in       = 1'b1;
               state_in     = S_IDLE;
            end else if (ptr_ff < fcount_ff) begin
               rd_en  = 1'b1;
               rdv_in = 1'b1;
               ptr_in = ptr_ff + FCW'(1);
            end else begin
               launch_in = 1'b1;
               state_in  = S_ROUTE;
            end
         end
         S_ROUTE: begin
            if (chain_q[ROUTE_ENTRIES].valid) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b0;
               state_in     = S_IDLE;
               if (chain_q[ROUTE_ENTRIES].found) begin
                  status_in = rlfc_pkg::ST_FOUND;
                  ridx_in   = wr_route;
                  if (fcount_ff < FCW'(FLOW_ENTRIES)) begin
                     wr_en     = 1'b1;
                     fcount_in = fcount_ff + FCW'(1);
                  end
               end else begin
                  status_in = rlfc_pkg::ST_NONE;
                  ridx_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_q  <= flow_addr_mem[ptr_ff[FW-1:0]];
         rd_route_q <= flow_route_mem[ptr_ff[FW-1:0]];
      end
      if (wr_en) begin
         flow_addr_mem[fcount_ff[FW-1:0]]  <= qaddr_ff;
         flow_route_mem[fcount_ff[FW-1:0]] <= wr_route;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      qaddr_ff  <= qaddr_in;
      status_ff <= status_in;
      ridx_ff   <= ridx_in;
      hit_ff    <= hit_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rcount_ff    <= '0;
         fcount_ff    <= '0;
         rdv_ff       <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcount_ff    <= rcount_in;
         fcount_ff    <= fcount_in;
         rdv_ff       <= rdv_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, ridx_ff};
   assign rsp_tuser  = {hit_ff, status_ff};

endmodule
`default_nettype wire
